// File: rtl/core/scs_pkg.sv
// Shared definitions for the shortest common supersequence block.
// Holds the input mode codes and the command/status bundles between
// controller and datapath. No dependencies.
package scs_pkg;

  localparam logic [1:0] ModeAppendA = 2'd0;
  localparam logic [1:0] ModeAppendB = 2'd1;
  localparam logic [1:0] ModeCompute = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load_a;     // append symbol to first string
    logic load_b;     // append symbol to second string
    logic start;      // compute accepted: latch and clear drop flag
    logic fill_init;  // i = 1, j = 1
    logic row_rd;     // read first string at row i
    logic fill_rd;    // read second string and table cell above
    logic fill_wr;    // compute and write one table cell
    logic tb_init;    // i = n, j = m, count = 0
    logic tb_rd1;     // read both strings and table cell above
    logic tb_rd2;     // latch cell above, read cell to the left
    logic tb_dec;     // decide and store one trace symbol
    logic left_rd;    // read leftover symbol
    logic left_wr;    // store leftover symbol
    logic emit_init;  // start emission, clear string lengths
    logic emit_rd;    // read next trace symbol
    logic emit_ld;    // load output register with trace symbol
    logic empty_ld;   // load output register with empty marker
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic both_empty;
    logic fill_skip;
    logic row_end;
    logic col_end;
    logic both_pos;
    logic any_left;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/scs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module scs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/scs_ctrl.sv
// Sequencer for the supersequence block: load, table fill, traceback, emit.
// Depends on scs_pkg for the mode codes and command/status bundles.
module scs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    mode_i,
  output logic          in_ready_o,
  input  scs_pkg::sts_t sts_i,
  output scs_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    StIdle    = 13'h0001,
    StFillRow = 13'h0002,
    StFillRd  = 13'h0004,
    StFillWr  = 13'h0008,
    StTbChk   = 13'h0010,
    StTbRd1   = 13'h0020,
    StTbRd2   = 13'h0040,
    StTbDec   = 13'h0080,
    StLeftRd  = 13'h0100,
    StLeftWr  = 13'h0200,
    StEmitRd  = 13'h0400,
    StEmitLd  = 13'h0800,
    StEmpty   = 13'h1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_a = (mode_i == scs_pkg::ModeAppendA);
          cmd_o.load_b = (mode_i == scs_pkg::ModeAppendB);
          if (mode_i == scs_pkg::ModeCompute) begin
            cmd_o.start = 1'b1;
            if (sts_i.both_empty) begin
              state_d = StEmpty;
            end else if (sts_i.fill_skip) begin
              cmd_o.tb_init = 1'b1;
              state_d       = StTbChk;
            end else begin
              cmd_o.fill_init = 1'b1;
              state_d         = StFillRow;
            end
          end
        end
      end
      StFillRow: begin
        cmd_o.row_rd = 1'b1;
        state_d      = StFillRd;
      end
      StFillRd: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = StFillWr;
      end
      StFillWr: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.row_end && sts_i.col_end) begin
          cmd_o.tb_init = 1'b1;
          state_d       = StTbChk;
        end else if (sts_i.row_end) begin
          state_d = StFillRow;
        end else begin
          state_d = StFillRd;
        end
      end
      StTbChk: begin
        if (sts_i.both_pos) begin
          state_d = StTbRd1;
        end else if (sts_i.any_left) begin
          state_d = StLeftRd;
        end else begin
          cmd_o.emit_init = 1'b1;
          state_d         = StEmitRd;
        end
      end
      StTbRd1: begin
        cmd_o.tb_rd1 = 1'b1;
        state_d      = StTbRd2;
      end
      StTbRd2: begin
        cmd_o.tb_rd2 = 1'b1;
        state_d      = StTbDec;
      end
      StTbDec: begin
        cmd_o.tb_dec = 1'b1;
        state_d      = StTbChk;
      end
      StLeftRd: begin
        cmd_o.left_rd = 1'b1;
        state_d       = StLeftWr;
      end
      StLeftWr: begin
        cmd_o.left_wr = 1'b1;
        state_d       = StTbChk;
      end
      StEmitRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = StEmitLd;
      end
      StEmitLd: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d       = sts_i.emit_last ? StIdle : StEmitRd;
        end
      end
      StEmpty: begin
        if (sts_i.out_free) begin
          cmd_o.empty_ld = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/scs_dp.sv
// Datapath: string, LCS table and trace memories, index counters, output register.
// Depends on scs_pkg and scs_ram.
module scs_dp #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scs_pkg::cmd_t cmd_i,
  output scs_pkg::sts_t sts_o,
  input  logic [7:0]    symbol_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_symbol_o,
  output logic          last_o,
  output logic          empty_res_o,
  output logic          overflow_o
);

  localparam int unsigned LW     = $clog2(MAX_LEN + 1);
  localparam int unsigned SAW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned TDEPTH = MAX_LEN * MAX_LEN;
  localparam int unsigned TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int unsigned BDEPTH = 2 * MAX_LEN;
  localparam int unsigned BAW    = $clog2(BDEPTH);
  localparam int unsigned CW     = $clog2(BDEPTH + 1);

  logic [LW-1:0] len_a_q, len_b_q, i_q, j_q;
  logic [CW-1:0] cnt_q, e_q;
  logic [LW-1:0] left_q, diag_q, up_q;
  logic          dropped_q, ovf_q;
  logic          out_valid_q, last_q, empty_q, ovf_out_q;
  logic [7:0]    out_sym_q;

  logic [LW-1:0] i_dec, j_dec;
  logic [CW-1:0] e_dec;
  logic [7:0]    a_rdata, b_rdata, tr_rdata;
  logic [LW-1:0] t_rdata;
  logic          a_we, b_we, a_re, b_re, t_re, tr_we;
  logic [TAW-1:0] row_cur, row_prev, col_cur, col_prev, t_waddr, t_raddr;
  logic          first_col, first_row, sym_eq, pick_a;
  logic [LW-1:0] up_fill, lft, dg, cell_val, tb_left;
  logic [7:0]    tr_wdata;

  assign i_dec = i_q - LW'(1);
  assign j_dec = j_q - LW'(1);
  assign e_dec = e_q - CW'(1);

  // string stores
  assign a_we = cmd_i.load_a && (len_a_q < LW'(MAX_LEN));
  assign b_we = cmd_i.load_b && (len_b_q < LW'(MAX_LEN));
  assign a_re = cmd_i.row_rd || cmd_i.tb_rd1 || (cmd_i.left_rd && (i_q != '0));
  assign b_re = cmd_i.fill_rd || cmd_i.tb_rd1 || (cmd_i.left_rd && (j_q != '0));

  scs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (len_a_q[SAW-1:0]),
    .wdata_i (symbol_i),
    .re_i    (a_re),
    .raddr_i (i_dec[SAW-1:0]),
    .rdata_o (a_rdata)
  );

  scs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (len_b_q[SAW-1:0]),
    .wdata_i (symbol_i),
    .re_i    (b_re),
    .raddr_i (j_dec[SAW-1:0]),
    .rdata_o (b_rdata)
  );

  // LCS table holds rows/columns 1..n, 1..m; row and column zero read as zero
  assign row_cur  = TAW'(i_q - LW'(1)) * TAW'(MAX_LEN);
  assign row_prev = TAW'(i_q - LW'(2)) * TAW'(MAX_LEN);
  assign col_cur  = TAW'(j_q - LW'(1));
  assign col_prev = TAW'(j_q - LW'(2));
  assign t_waddr  = row_cur + col_cur;
  assign t_raddr  = cmd_i.tb_rd2 ? (row_cur + col_prev) : (row_prev + col_cur);
  assign first_row = (i_q == LW'(1));
  assign first_col = (j_q == LW'(1));
  assign t_re = ((cmd_i.fill_rd || cmd_i.tb_rd1) && !first_row) ||
                (cmd_i.tb_rd2 && !first_col);

  assign sym_eq   = (a_rdata == b_rdata);
  assign up_fill  = first_row ? '0 : t_rdata;
  assign lft      = first_col ? '0 : left_q;
  assign dg       = first_col ? '0 : diag_q;
  assign cell_val = sym_eq ? (dg + LW'(1)) : ((up_fill > lft) ? up_fill : lft);

  scs_ram #(.WIDTH(LW), .DEPTH(TDEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fill_wr),
    .waddr_i (t_waddr),
    .wdata_i (cell_val),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  // traceback decision
  assign tb_left  = first_col ? '0 : t_rdata;
  assign pick_a   = sym_eq || (up_q > tb_left);
  assign tr_we    = cmd_i.tb_dec || cmd_i.left_wr;
  assign tr_wdata = cmd_i.tb_dec ? (pick_a ? a_rdata : b_rdata)
                                 : ((i_q != '0) ? a_rdata : b_rdata);

  scs_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_trace (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (cnt_q[BAW-1:0]),
    .wdata_i (tr_wdata),
    .re_i    (cmd_i.emit_rd),
    .raddr_i (e_dec[BAW-1:0]),
    .rdata_o (tr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q   <= '0;
      len_b_q   <= '0;
      dropped_q <= 1'b0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      cnt_q     <= '0;
      e_q       <= '0;
    end else begin
      if (a_we) len_a_q <= len_a_q + LW'(1);
      if (b_we) len_b_q <= len_b_q + LW'(1);
      if ((cmd_i.load_a && !a_we) || (cmd_i.load_b && !b_we)) begin
        dropped_q <= 1'b1;
      end
      if (cmd_i.start) begin
        ovf_q     <= dropped_q;
        dropped_q <= 1'b0;
      end
      if (cmd_i.fill_init) begin
        i_q <= LW'(1);
        j_q <= LW'(1);
      end
      // the final fill step hands over to tb_init instead
      if (cmd_i.fill_wr && !cmd_i.tb_init) begin
        if (j_q == len_b_q) begin
          i_q <= i_q + LW'(1);
          j_q <= LW'(1);
        end else begin
          j_q <= j_q + LW'(1);
        end
      end
      if (cmd_i.tb_dec) begin
        cnt_q <= cnt_q + CW'(1);
        if (sym_eq) begin
          i_q <= i_dec;
          j_q <= j_dec;
        end else if (pick_a) begin
          i_q <= i_dec;
        end else begin
          j_q <= j_dec;
        end
      end
      if (cmd_i.left_wr) begin
        cnt_q <= cnt_q + CW'(1);
        if (i_q != '0) begin
          i_q <= i_dec;
        end else begin
          j_q <= j_dec;
        end
      end
      if (cmd_i.tb_init) begin
        i_q   <= len_a_q;
        j_q   <= len_b_q;
        cnt_q <= '0;
      end
      if (cmd_i.emit_init) begin
        e_q     <= cnt_q;
        len_a_q <= '0;
        len_b_q <= '0;
      end
      if (cmd_i.emit_ld) begin
        e_q <= e_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr) begin
      left_q <= cell_val;
      diag_q <= up_fill;
    end
    if (cmd_i.tb_rd2) begin
      up_q <= first_row ? '0 : t_rdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ld || cmd_i.empty_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_sym_q <= tr_rdata;
      last_q    <= (e_q == CW'(1));
      empty_q   <= 1'b0;
      ovf_out_q <= ovf_q;
    end else if (cmd_i.empty_ld) begin
      out_sym_q <= '0;
      last_q    <= 1'b1;
      empty_q   <= 1'b1;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign last_o       = last_q;
  assign empty_res_o  = empty_q;
  assign overflow_o   = ovf_out_q;

  assign sts_o.both_empty = (len_a_q == '0) && (len_b_q == '0);
  assign sts_o.fill_skip  = (len_a_q == '0) || (len_b_q == '0);
  assign sts_o.row_end    = (j_q == len_b_q);
  assign sts_o.col_end    = (i_q == len_a_q);
  assign sts_o.both_pos   = (i_q != '0) && (j_q != '0);
  assign sts_o.any_left   = (i_q != '0) || (j_q != '0);
  assign sts_o.emit_last  = (e_q == CW'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// File: rtl/core/shortest_common_supersequence.sv
// Shortest common supersequence of two byte strings via an LCS length table.
// Input channel: in_valid_i/in_ready_o with mode_i and symbol_i. Mode 0 appends
// symbol_i to the first string, mode 1 to the second (at most MAX_LEN each;
// extra symbols are dropped and reported through overflow_o), mode 3 is ignored.
// Mode 2 computes: the block fills the table (n*m cells), reading the first
// string once per row and, per cell, the second string and the cell above
// before writing it; it traces back (at most n+m steps, then leftovers), each
// step reading both strings and the cells above and to the left, then storing
// one symbol; it then emits the supersequence in forward order on out_valid_o/
// out_ready_i; last_o marks the final symbol. Both strings empty gives a
// single transaction with empty_res_o and last_o set. Both strings are cleared
// once emission starts. in_ready_o is high only while idle; it returns after
// the final symbol is placed in the output register, so new loads may proceed
// while that symbol waits. A stalled receiver holds the output register and the
// sequencer. Reset empties both strings, clears the drop flag and the output.
// Depends on scs_pkg, scs_ram, scs_ctrl and scs_dp.
module shortest_common_supersequence #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       last_o,
  output logic       empty_res_o,
  output logic       overflow_o
);

  scs_pkg::cmd_t cmd;
  scs_pkg::sts_t sts;

  scs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .symbol_i     (symbol_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_symbol_o (out_symbol_o),
    .last_o       (last_o),
    .empty_res_o  (empty_res_o),
    .overflow_o   (overflow_o)
  );

  // never overwrite a result that the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_ld || cmd.empty_ld) |-> sts.out_free)
    else $error("output register overwritten while pending");

  // an empty result is always the final transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> last_o)
    else $error("empty result without last");

  // a compute transaction takes the sequencer out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == scs_pkg::ModeCompute)) |=> !in_ready_o)
    else $error("ready stayed high after compute");

endmodule

// File: tb/shortest_common_supersequence_tb.sv
// Self-checking testbench for shortest_common_supersequence: loads string pairs,
// computes, and checks every output transaction against a built-in LCS predictor.
// Depends on scs_pkg and the shortest_common_supersequence RTL.
`timescale 1ns / 100ps

module shortest_common_supersequence_tb;

  localparam int unsigned MaxLen     = 32;
  localparam int unsigned ItemTarget = 250;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 200;
  localparam logic [1:0]  ModeUnused = 2'd3;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       empty;
    logic       ovf;
  } scs_result_t;

  class scs_scoreboard;
    logic [7:0]  str_a [MaxLen];
    logic [7:0]  str_b [MaxLen];
    int unsigned len_a;
    int unsigned len_b;
    bit          dropped;
    scs_result_t supersequence_q[$];
    int unsigned error_count;

    function new();
      len_a       = 0;
      len_b       = 0;
      dropped     = 1'b0;
      error_count = 0;
    endfunction

    function int unsigned pending();
      return supersequence_q.size();
    endfunction

    function void expect_result(scs_result_t r);
      supersequence_q.insert(supersequence_q.size(), r);
    endfunction

    // Fill the LCS table, trace back from the end and queue the merge in order.
    function void predict_supersequence();
      int unsigned lcs [0:MaxLen][0:MaxLen];
      logic [7:0]  merged[$];
      scs_result_t r;
      int          i;
      int          j;
      bit          ovf;
      ovf = dropped;
      if (len_a == 0 && len_b == 0) begin
        r.sym   = 8'h00;
        r.last  = 1'b1;
        r.empty = 1'b1;
        r.ovf   = ovf;
        expect_result(r);
      end else begin
        for (i = 0; i <= len_a; i++) begin
          for (j = 0; j <= len_b; j++) begin
            if (i == 0 || j == 0) begin
              lcs[i][j] = 0;
            end else if (str_a[i-1] == str_b[j-1]) begin
              lcs[i][j] = lcs[i-1][j-1] + 1;
            end else begin
              lcs[i][j] = (lcs[i-1][j] > lcs[i][j-1]) ? lcs[i-1][j] : lcs[i][j-1];
            end
          end
        end
        i = len_a;
        j = len_b;
        // On a tie take the second string's symbol.
        while (i > 0 && j > 0) begin
          if (str_a[i-1] == str_b[j-1]) begin
            merged.push_front(str_a[i-1]);
            i--;
            j--;
          end else if (lcs[i-1][j] > lcs[i][j-1]) begin
            merged.push_front(str_a[i-1]);
            i--;
          end else begin
            merged.push_front(str_b[j-1]);
            j--;
          end
        end
        while (i > 0) begin
          merged.push_front(str_a[i-1]);
          i--;
        end
        while (j > 0) begin
          merged.push_front(str_b[j-1]);
          j--;
        end
        foreach (merged[k]) begin
          r.sym   = merged[k];
          r.last  = (k == merged.size() - 1);
          r.empty = 1'b0;
          r.ovf   = ovf;
          expect_result(r);
        end
      end
      len_a   = 0;
      len_b   = 0;
      dropped = 1'b0;
    endfunction

    function void note_transaction(logic [1:0] mode, logic [7:0] sym);
      case (mode)
        scs_pkg::ModeAppendA: begin
          if (len_a < MaxLen) begin
            str_a[len_a] = sym;
            len_a++;
          end else begin
            dropped = 1'b1;
          end
        end
        scs_pkg::ModeAppendB: begin
          if (len_b < MaxLen) begin
            str_b[len_b] = sym;
            len_b++;
          end else begin
            dropped = 1'b1;
          end
        end
        scs_pkg::ModeCompute: predict_supersequence();
        default: ;  // unused mode leaves everything as it is
      endcase
    endfunction

    function void check_transaction(logic [7:0] sym, logic last, logic empty, logic ovf);
      scs_result_t want;
      if (supersequence_q.size() == 0) begin
        $error("unexpected output transaction: out_symbol %h", sym);
        error_count++;
        return;
      end
      want = supersequence_q.pop_front();
      // The symbol carries no meaning on an empty result.
      if (!want.empty && sym !== want.sym) begin
        $error("out_symbol: expected %h, got %h", want.sym, sym);
        error_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, got %b", want.last, last);
        error_count++;
      end
      if (empty !== want.empty) begin
        $error("empty_res: expected %b, got %b", want.empty, empty);
        error_count++;
      end
      if (ovf !== want.ovf) begin
        $error("overflow: expected %b, got %b", want.ovf, ovf);
        error_count++;
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] mode_i      = 2'd0;
  logic [7:0] symbol_i    = 8'd0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_symbol_o;
  logic       last_o;
  logic       empty_res_o;
  logic       overflow_o;

  scs_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int unsigned   items_sent  = 0;
  int unsigned   rx_free     = 0;
  int unsigned   rx_hold     = 0;
  bit            steady      = 1'b0;

  shortest_common_supersequence #(
    .MAX_LEN(MaxLen)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_symbol_o(out_symbol_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .overflow_o  (overflow_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: runs of ready, broken by stalls; some runs are long.
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      out_ready_i = 1'b0;
      rx_hold--;
    end else begin
      out_ready_i = 1'b1;
      if (rx_free != 0) begin
        rx_free--;
      end else begin
        rx_free = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 6);
        rx_hold = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_transaction(out_symbol_o, last_o, empty_res_o, overflow_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("shortest_common_supersequence_tb: errors");
      $finish;
    end
  end

  // Drive one transaction, hold until accepted, then idle for a random gap.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] sym);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i     = mode;
    symbol_i   = sym;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transaction(mode, sym);
    if (mode != ModeUnused) items_sent++;
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      mode_i     = 2'($urandom_range(0, 3));
      symbol_i   = 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Load two strings in random interleaving, with some ignored noise, then compute.
  task automatic run_job(input int unsigned n_a, input int unsigned n_b, input bit narrow);
    int unsigned left_a;
    int unsigned left_b;
    logic [1:0]  mode;
    logic [7:0]  sym;
    left_a = n_a;
    left_b = n_b;
    while (left_a + left_b > 0) begin
      if (left_a > 0 && (left_b == 0 || $urandom_range(0, 1) == 1)) begin
        mode = scs_pkg::ModeAppendA;
        left_a--;
      end else begin
        mode = scs_pkg::ModeAppendB;
        left_b--;
      end
      sym = narrow ? 8'h41 + 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) send_item(ModeUnused, 8'($urandom_range(0, 255)));
      send_item(mode, sym);
    end
    send_item(scs_pkg::ModeCompute, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned n_a;
    int unsigned n_b;
    int unsigned kind;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: empty compute, ignored mode, byte extremes, one-sided jobs, a tie.
    send_item(scs_pkg::ModeCompute, 8'hA5);
    send_item(ModeUnused, 8'hFF);
    send_item(scs_pkg::ModeAppendA, 8'h00);
    send_item(scs_pkg::ModeAppendA, 8'hFF);
    send_item(scs_pkg::ModeAppendB, 8'hFF);
    send_item(scs_pkg::ModeAppendB, 8'h80);
    send_item(ModeUnused, 8'h55);
    send_item(scs_pkg::ModeCompute, 8'h00);
    send_item(scs_pkg::ModeAppendA, 8'h12);
    send_item(scs_pkg::ModeAppendA, 8'h34);
    send_item(scs_pkg::ModeCompute, 8'hFF);
    send_item(scs_pkg::ModeAppendB, 8'h01);
    send_item(scs_pkg::ModeCompute, 8'h5A);
    send_item(scs_pkg::ModeAppendA, 8'h78);
    send_item(scs_pkg::ModeAppendB, 8'h79);
    send_item(scs_pkg::ModeCompute, 8'h00);
    wait_drained();

    // Largest job, first string overfilled by one.
    run_job(MaxLen + 1, MaxLen, 1'b1);

    while (items_sent < ItemTarget) begin
      steady = ($urandom_range(0, 3) == 0);
      kind   = $urandom_range(0, 19);
      if (kind == 0) begin
        n_a = $urandom_range(0, 3);
        n_b = MaxLen + $urandom_range(1, 2);
        if ($urandom_range(0, 1) == 1) begin
          n_a = n_b;
          n_b = $urandom_range(0, 3);
        end
      end else if (kind == 1) begin
        n_a = $urandom_range(8, MaxLen);
        n_b = $urandom_range(8, MaxLen);
      end else begin
        n_a = $urandom_range(0, 6);
        n_b = $urandom_range(0, 6);
      end
      run_job(n_a, n_b, $urandom_range(0, 2) != 0);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("shortest_common_supersequence_tb: clean");
    end else begin
      $display("shortest_common_supersequence_tb: errors");
    end
    $finish;
  end

endmodule
